// ----- hw/rtl/langevin_gear_corrector_step_assert.svh -----
// assertion macros for the gear corrector step checker
// no dependencies; included by the checker file
`ifndef LANGEVIN_GEAR_CORRECTOR_STEP_ASSERT_SVH
`define LANGEVIN_GEAR_CORRECTOR_STEP_ASSERT_SVH

// same-cycle implication
`define LGC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/lgc_pkg.sv -----
// shared constants, types and helper functions of the gear corrector step
// no dependencies; used by every rtl module
package lgc_pkg;

   localparam int PARTICLES  = 1024;
   localparam int ADDR_W     = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int DATA_W     = 48;
   localparam int PARTICLE_W = 10;
   localparam int ORDER_W    = 3;
   localparam int ROWS       = 6;
   localparam int AXES       = 3;
   localparam int CSR_IDX_W  = 3;

   // pipeline: stage 1 holds memory read data, rows written back from stage 13,
   // result shown from stage 15
   localparam int PIPE_DEPTH = 15;
   localparam int WB_STAGE   = 13;

   localparam logic FUNC_INTEGRATE = 1'b0;
   localparam logic FUNC_LOAD      = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_DT_SQ  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SCALE = 3'd3;

   localparam logic [DATA_W-1:0] RST_HALF_DT_SQ  = 48'd53687;
   localparam logic [DATA_W-1:0] RST_INV_DT      = 48'd858993459200;
   localparam logic [DATA_W-1:0] RST_GAMMA       = 48'd4294967296;
   localparam logic [DATA_W-1:0] RST_NOISE_SCALE = 48'd0;

   // corrector weights 3/16, 251/360, 1, 11/18, 1/6, 1/60 in unsigned q16.32
   localparam logic [ROWS-1:0][DATA_W-1:0] COEF = {
      48'd71582788, 48'd715827883, 48'd2624702236,
      48'd4294967296, 48'd2994546642, 48'd805306368};

   localparam logic signed [55:0] SMAX56 = 56'sd140737488355327;
   localparam logic signed [55:0] SMIN56 = -56'sd140737488355328;

   typedef logic [ROWS-1:0][DATA_W-1:0] rows_type;
   typedef logic [AXES-1:0][DATA_W-1:0] axes_type;

   typedef struct packed {
      logic [DATA_W-1:0] half_dt_sq;
      logic [DATA_W-1:0] inv_dt;
   } lane_cfg_type;

   function automatic logic signed [55:0] sx56(input logic [DATA_W-1:0] v);
      return {{8{v[DATA_W-1]}}, v};
   endfunction

   function automatic logic [DATA_W-1:0] sat56(input logic signed [55:0] v);
      logic [DATA_W-1:0] r;
      if (v > SMAX56) begin
         r = SMAX56[DATA_W-1:0];
      end else if (v < SMIN56) begin
         r = SMIN56[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/lgc_mul.sv -----
// two-stage q16.32 multiplier with rounding and saturation
// depends on lgc_pkg
module lgc_mul (
   input  logic                      clock,
   input  logic [lgc_pkg::DATA_W-1:0] a,
   input  logic [lgc_pkg::DATA_W-1:0] b,
   input  logic                      is_signed,
   output logic [lgc_pkg::DATA_W-1:0] p
);

   logic                       neg;
   logic [lgc_pkg::DATA_W-1:0] mag;
   logic [31:0]                hh_in, hh_ff;
   logic [47:0]                hl_in, hl_ff, lh_in, lh_ff;
   logic [63:0]                ll_in, ll_ff;
   logic                       neg_ff, sgn_ff;
   logic [lgc_pkg::DATA_W-1:0] cap;
   logic [63:0]                rnd_sum, r;
   logic [lgc_pkg::DATA_W-1:0] mag_out, p_in, p_ff;

   // stage 1: sign split and four partial products
   assign neg   = is_signed & a[lgc_pkg::DATA_W-1];
   assign mag   = neg ? (48'd0 - a) : a;
   assign hh_in = mag[47:32] * b[47:32];
   assign hl_in = mag[47:32] * b[31:0];
   assign lh_in = mag[31:0] * b[47:32];
   assign ll_in = mag[31:0] * b[31:0];

   always_ff @(posedge clock) begin
      hh_ff  <= hh_in;
      hl_ff  <= hl_in;
      lh_ff  <= lh_in;
      ll_ff  <= ll_in;
      neg_ff <= neg;
      sgn_ff <= is_signed;
   end

   // stage 2: sum, round, clamp
   always_comb begin
      if (neg_ff) begin
         cap = 48'h8000_0000_0000;
      end else if (sgn_ff) begin
         cap = 48'h7FFF_FFFF_FFFF;
      end else begin
         cap = 48'hFFFF_FFFF_FFFF;
      end
      rnd_sum = ll_ff + 64'h8000_0000;
      r = 64'({hh_ff[15:0], 32'd0}) + 64'(hl_ff) + 64'(lh_ff) + 64'(rnd_sum[63:32]);
      if ((|hh_ff[31:16]) || (r > 64'(cap))) begin
         mag_out = cap;
      end else begin
         mag_out = r[lgc_pkg::DATA_W-1:0];
      end
      p_in = neg_ff ? (48'd0 - mag_out) : mag_out;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

// ----- hw/rtl/lgc_lane.sv -----
// one axis lane: acceleration, gear corrector and pascal predictor
// depends on lgc_pkg and lgc_mul
module lgc_lane (
   input  logic                       clock,
   input  lgc_pkg::lane_cfg_type      cfg,
   input  lgc_pkg::rows_type          rows_in,
   input  logic [lgc_pkg::DATA_W-1:0] force_in,
   input  logic [lgc_pkg::DATA_W-1:0] noise_in,
   input  logic [lgc_pkg::DATA_W-1:0] inv_mass,
   input  logic [lgc_pkg::DATA_W-1:0] gam,
   input  logic [lgc_pkg::DATA_W-1:0] nsd,
   output lgc_pkg::rows_type          rows_out,
   output logic [lgc_pkg::DATA_W-1:0] pos,
   output logic [lgc_pkg::DATA_W-1:0] vel
);

   localparam int YDLY = 10;

   lgc_pkg::rows_type          rows_dly_ff [YDLY];
   logic [lgc_pkg::DATA_W-1:0] f, v1, fr, nz, t, vel_p;
   logic [lgc_pkg::DATA_W-1:0] noise_d1_ff, noise_d2_ff, f_d1_ff, f_d2_ff;
   logic [lgc_pkg::DATA_W-1:0] a_in, a_ff, e_in, e_ff;
   logic [lgc_pkg::DATA_W-1:0] prod [lgc_pkg::ROWS];
   lgc_pkg::rows_type          c_in, c_ff, ynew_in, ynew_ff;
   logic [lgc_pkg::DATA_W-1:0] pos_d1_ff, pos_d2_ff;
   logic signed [55:0]         cx [lgc_pkg::ROWS];

   // row delay line, entry i holds stage i+2
   always_ff @(posedge clock) begin
      rows_dly_ff[0] <= rows_in;
      for (int i = 1; i < YDLY; i++) begin
         rows_dly_ff[i] <= rows_dly_ff[i-1];
      end
      noise_d1_ff <= noise_in;
      noise_d2_ff <= noise_d1_ff;
      f_d1_ff     <= f;
      f_d2_ff     <= f_d1_ff;
   end

   lgc_mul u_mul_f  (.clock, .a(force_in), .b(inv_mass), .is_signed(1'b1), .p(f));
   lgc_mul u_mul_v1 (.clock, .a(rows_in[1]), .b(cfg.inv_dt), .is_signed(1'b1), .p(v1));
   lgc_mul u_mul_fr (.clock, .a(v1), .b(gam), .is_signed(1'b1), .p(fr));
   lgc_mul u_mul_nz (.clock, .a(noise_d2_ff), .b(nsd), .is_signed(1'b1), .p(nz));

   assign a_in = lgc_pkg::sat56(lgc_pkg::sx56(lgc_pkg::sat56(
                    lgc_pkg::sx56(f_d2_ff) - lgc_pkg::sx56(fr))) + lgc_pkg::sx56(nz));

   always_ff @(posedge clock) begin
      a_ff <= a_in;
   end

   lgc_mul u_mul_t (.clock, .a(a_ff), .b(cfg.half_dt_sq), .is_signed(1'b1), .p(t));

   assign e_in = lgc_pkg::sat56(lgc_pkg::sx56(rows_dly_ff[6][2]) - lgc_pkg::sx56(t));

   always_ff @(posedge clock) begin
      e_ff <= e_in;
   end

   for (genvar k = 0; k < lgc_pkg::ROWS; k++) begin : g_corr
      lgc_mul u_mul_c (.clock, .a(e_ff), .b(lgc_pkg::COEF[k]), .is_signed(1'b1),
                       .p(prod[k]));
      assign c_in[k] = lgc_pkg::sat56(lgc_pkg::sx56(rows_dly_ff[9][k]) -
                                      lgc_pkg::sx56(prod[k]));
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
   end

   // pascal triangle predictor, rows 0 to 4 each saturated once, row 5 passed through
   always_comb begin
      for (int k = 0; k < lgc_pkg::ROWS; k++) begin
         cx[k] = lgc_pkg::sx56(c_ff[k]);
      end
      ynew_in[0] = lgc_pkg::sat56(cx[0] + cx[1] + cx[2] + cx[3] + cx[4] + cx[5]);
      ynew_in[1] = lgc_pkg::sat56(cx[1] + 2 * cx[2] + 3 * cx[3] + 4 * cx[4] + 5 * cx[5]);
      ynew_in[2] = lgc_pkg::sat56(cx[2] + 3 * cx[3] + 6 * cx[4] + 10 * cx[5]);
      ynew_in[3] = lgc_pkg::sat56(cx[3] + 4 * cx[4] + 10 * cx[5]);
      ynew_in[4] = lgc_pkg::sat56(cx[4] + 5 * cx[5]);
      ynew_in[5] = c_ff[5];
   end

   always_ff @(posedge clock) begin
      ynew_ff   <= ynew_in;
      pos_d1_ff <= ynew_ff[0];
      pos_d2_ff <= pos_d1_ff;
   end

   lgc_mul u_mul_vel (.clock, .a(ynew_ff[1]), .b(cfg.inv_dt), .is_signed(1'b1),
                      .p(vel_p));

   assign rows_out = ynew_ff;
   assign pos      = pos_d2_ff;
   assign vel      = vel_p;

endmodule

// ----- hw/rtl/langevin_gear_corrector_step.sv -----
// top level of the langevin gear predictor-corrector step
// depends on lgc_pkg, lgc_mul and lgc_lane
//
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// request   | start / busy         | req_func, req_particle, req_order, force,
//           |                      | noise, mass terms
// response  | rsp_valid (strobe)   | rsp_particle_out, rsp_pos_*, rsp_vel_*
// csr write | csr_valid / csr_ready| csr_index, csr_data
//
// one item per cycle while busy is low; an integrate result leaves from the last pipeline stage
// latency is set by the dependent multiplier chain
// busy is high in reset and rises while a request's particle is still in flight up to write-back,
// and for a load in a cycle that writes back an integrate (one memory port)
// reset is synchronous, clears the pipeline valids and sets the control registers to their defaults;
// the derivative memory has no reset and must be loaded before integrating
// the receiver cannot stall: results leave on the strobe cycle
module langevin_gear_corrector_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [lgc_pkg::PARTICLE_W-1:0]      req_particle,
   input  logic [lgc_pkg::ORDER_W-1:0]         req_order,
   input  logic signed [lgc_pkg::DATA_W-1:0]   req_force_x,
   input  logic signed [lgc_pkg::DATA_W-1:0]   req_force_y,
   input  logic signed [lgc_pkg::DATA_W-1:0]   req_force_z,
   input  logic signed [lgc_pkg::DATA_W-1:0]   req_noise_x,
   input  logic signed [lgc_pkg::DATA_W-1:0]   req_noise_y,
   input  logic signed [lgc_pkg::DATA_W-1:0]   req_noise_z,
   input  logic [lgc_pkg::DATA_W-1:0]          req_mass,
   input  logic [lgc_pkg::DATA_W-1:0]          req_inv_mass,
   input  logic [lgc_pkg::DATA_W-1:0]          req_rsqrt_mass,
   output logic                                rsp_valid,
   output logic [lgc_pkg::PARTICLE_W-1:0]      rsp_particle_out,
   output logic signed [lgc_pkg::DATA_W-1:0]   rsp_pos_x,
   output logic signed [lgc_pkg::DATA_W-1:0]   rsp_pos_y,
   output logic signed [lgc_pkg::DATA_W-1:0]   rsp_pos_z,
   output logic signed [lgc_pkg::DATA_W-1:0]   rsp_vel_x,
   output logic signed [lgc_pkg::DATA_W-1:0]   rsp_vel_y,
   output logic signed [lgc_pkg::DATA_W-1:0]   rsp_vel_z,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lgc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lgc_pkg::DATA_W-1:0]          csr_data
);

   // control and status registers
   logic [lgc_pkg::DATA_W-1:0] hdt_ff, hdt_in, inv_dt_ff, inv_dt_in;
   logic [lgc_pkg::DATA_W-1:0] gamma_ff, gamma_in, nscale_ff, nscale_in;
   lgc_pkg::lane_cfg_type      lane_cfg;

   // request side
   logic                       acc;
   logic                       hazard;
   logic [31:0]                req_ext;
   logic                       req_in_range;
   logic [lgc_pkg::ADDR_W-1:0] raddr;
   logic                       ld_we;
   lgc_pkg::axes_type          ld_val;

   // pipeline control, bit i is stage i+1
   logic [lgc_pkg::PIPE_DEPTH-1:0]  vld_ff, vld_in, rng_ff, rng_in;
   logic [lgc_pkg::PARTICLE_W-1:0]  part_ff [lgc_pkg::PIPE_DEPTH];

   // stage 1 payload
   lgc_pkg::axes_type          force_ff, noise_ff;
   logic [lgc_pkg::DATA_W-1:0] mass_ff, inv_mass_ff, rsqrt_ff;
   lgc_pkg::axes_type          rd_rows [lgc_pkg::ROWS];
   logic [lgc_pkg::DATA_W-1:0] gam, nsd;

   // write-back
   logic                       wb_we;
   logic [31:0]                wb_ext;
   logic [lgc_pkg::ADDR_W-1:0] wb_addr;
   logic [lgc_pkg::ADDR_W-1:0] waddr;

   // lanes
   lgc_pkg::rows_type          lane_rows_in  [lgc_pkg::AXES];
   lgc_pkg::rows_type          lane_rows_out [lgc_pkg::AXES];
   logic [lgc_pkg::DATA_W-1:0] lane_pos [lgc_pkg::AXES];
   logic [lgc_pkg::DATA_W-1:0] lane_vel [lgc_pkg::AXES];
   logic                       out_rng;

   // csr port, always ready; writes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      hdt_in    = hdt_ff;
      inv_dt_in = inv_dt_ff;
      gamma_in  = gamma_ff;
      nscale_in = nscale_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lgc_pkg::CSR_HALF_DT_SQ:  hdt_in    = csr_data;
            lgc_pkg::CSR_INV_DT:      inv_dt_in = csr_data;
            lgc_pkg::CSR_GAMMA:       gamma_in  = csr_data;
            lgc_pkg::CSR_NOISE_SCALE: nscale_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdt_ff    <= lgc_pkg::RST_HALF_DT_SQ;
         inv_dt_ff <= lgc_pkg::RST_INV_DT;
         gamma_ff  <= lgc_pkg::RST_GAMMA;
         nscale_ff <= lgc_pkg::RST_NOISE_SCALE;
      end else begin
         hdt_ff    <= hdt_in;
         inv_dt_ff <= inv_dt_in;
         gamma_ff  <= gamma_in;
         nscale_ff <= nscale_in;
      end
   end

   assign lane_cfg.half_dt_sq = hdt_ff;
   assign lane_cfg.inv_dt     = inv_dt_ff;

   // request decode and read-after-write hazard on the particle
   assign req_ext      = 32'(req_particle);
   assign req_in_range = req_ext < 32'(lgc_pkg::PARTICLES);
   assign raddr        = req_ext[lgc_pkg::ADDR_W-1:0];

   assign wb_we   = vld_ff[lgc_pkg::WB_STAGE-1] & rng_ff[lgc_pkg::WB_STAGE-1];
   assign wb_ext  = 32'(part_ff[lgc_pkg::WB_STAGE-1]);
   assign wb_addr = wb_ext[lgc_pkg::ADDR_W-1:0];

   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < lgc_pkg::WB_STAGE; i++) begin
         if (vld_ff[i] && (part_ff[i] == req_particle)) begin
            hazard = 1'b1;
         end
      end
   end

   assign busy = reset | hazard | ((req_func == lgc_pkg::FUNC_LOAD) & wb_we);
   assign acc  = start & ~busy;

   assign ld_we  = acc && (req_func == lgc_pkg::FUNC_LOAD) && req_in_range &&
                   (req_order < lgc_pkg::ORDER_W'(lgc_pkg::ROWS));
   assign ld_val = {req_force_z, req_force_y, req_force_x};
   assign waddr  = wb_we ? wb_addr : raddr;

   // pipeline valid, range flag and particle tag
   assign vld_in = {vld_ff[lgc_pkg::PIPE_DEPTH-2:0],
                    acc && (req_func == lgc_pkg::FUNC_INTEGRATE)};
   assign rng_in = {rng_ff[lgc_pkg::PIPE_DEPTH-2:0], req_in_range};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      rng_ff     <= rng_in;
      part_ff[0] <= req_particle;
      for (int i = 1; i < lgc_pkg::PIPE_DEPTH; i++) begin
         part_ff[i] <= part_ff[i-1];
      end
   end

   // stage 1 payload capture
   always_ff @(posedge clock) begin
      if (acc) begin
         force_ff    <= {req_force_z, req_force_y, req_force_x};
         noise_ff    <= {req_noise_z, req_noise_y, req_noise_x};
         mass_ff     <= req_mass;
         inv_mass_ff <= req_inv_mass;
         rsqrt_ff    <= req_rsqrt_mass;
      end
   end

   // derivative memory: one bank per row, three axes per word
   for (genvar k = 0; k < lgc_pkg::ROWS; k++) begin : g_row
      lgc_pkg::axes_type mem [lgc_pkg::PARTICLES];
      lgc_pkg::axes_type rd_ff;
      lgc_pkg::axes_type wdata;
      logic              we;

      assign we = wb_we | (ld_we && (req_order == lgc_pkg::ORDER_W'(k)));

      always_comb begin
         for (int ax = 0; ax < lgc_pkg::AXES; ax++) begin
            wdata[ax] = wb_we ? lane_rows_out[ax][k] : ld_val[ax];
         end
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[waddr] <= wdata;
         end
         if (acc) begin
            rd_ff <= mem[raddr];
         end
      end

      assign rd_rows[k] = rd_ff;
   end

   // per-particle friction and noise gains, shared by the three lanes
   lgc_mul u_mul_gam (.clock, .a(gamma_ff), .b(mass_ff), .is_signed(1'b0), .p(gam));
   lgc_mul u_mul_nsd (.clock, .a(nscale_ff), .b(rsqrt_ff), .is_signed(1'b0), .p(nsd));

   // axis lanes
   for (genvar ax = 0; ax < lgc_pkg::AXES; ax++) begin : g_lane
      always_comb begin
         for (int k = 0; k < lgc_pkg::ROWS; k++) begin
            lane_rows_in[ax][k] = rd_rows[k][ax];
         end
      end

      lgc_lane u_lane (
         .clock,
         .cfg      (lane_cfg),
         .rows_in  (lane_rows_in[ax]),
         .force_in (force_ff[ax]),
         .noise_in (noise_ff[ax]),
         .inv_mass (inv_mass_ff),
         .gam      (gam),
         .nsd      (nsd),
         .rows_out (lane_rows_out[ax]),
         .pos      (lane_pos[ax]),
         .vel      (lane_vel[ax])
      );
   end

   // merge: one result from the three lanes, zeros for an unknown particle
   assign out_rng          = rng_ff[lgc_pkg::PIPE_DEPTH-1];
   assign rsp_valid        = vld_ff[lgc_pkg::PIPE_DEPTH-1];
   assign rsp_particle_out = part_ff[lgc_pkg::PIPE_DEPTH-1];
   assign rsp_pos_x = out_rng ? lane_pos[0] : '0;
   assign rsp_pos_y = out_rng ? lane_pos[1] : '0;
   assign rsp_pos_z = out_rng ? lane_pos[2] : '0;
   assign rsp_vel_x = out_rng ? lane_vel[0] : '0;
   assign rsp_vel_y = out_rng ? lane_vel[1] : '0;
   assign rsp_vel_z = out_rng ? lane_vel[2] : '0;

endmodule

// ----- hw/rtl/lgc_checker.sv -----
// port-level checker for the gear corrector step, bound to the top level
// depends on lgc_pkg and langevin_gear_corrector_step_assert.svh
`include "langevin_gear_corrector_step_assert.svh"

module lgc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_func,
   input logic [lgc_pkg::PARTICLE_W-1:0] req_particle,
   input logic                           rsp_valid,
   input logic [lgc_pkg::PARTICLE_W-1:0] rsp_particle_out
);

   logic int_xfer;
   logic any_xfer;

   assign int_xfer = start && !busy && (req_func == lgc_pkg::FUNC_INTEGRATE);
   assign any_xfer = start && !busy;

   // every integrate transfer gives exactly one strobe, with its particle tag, after the fixed latency
   `LGC_ASSERT_IMPLY(a_int_gives_rsp, clock, reset, int_xfer, ##15 rsp_valid, "lost result")
   `LGC_ASSERT_IMPLY(a_rsp_from_int, clock, reset, rsp_valid, $past(int_xfer, 15), "extra result")
   `LGC_ASSERT_IMPLY(a_rsp_tag, clock, reset, rsp_valid,
      rsp_particle_out == $past(req_particle, 15), "wrong particle tag")
   // same particle cannot be taken again in the next cycle
   `LGC_ASSERT_NEXT(a_same_particle_blocked, clock, reset, int_xfer,
      !(any_xfer && (req_particle == $past(req_particle))), "hazard not blocked")

endmodule

bind langevin_gear_corrector_step lgc_checker u_lgc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_func         (req_func),
   .req_particle     (req_particle),
   .rsp_valid        (rsp_valid),
   .rsp_particle_out (rsp_particle_out)
);

// ----- sim/langevin_gear_corrector_step_chk.sv -----
// checker for the gear corrector step: watches request, csr and response channels
// predicts each integrate result in fixed point and compares it field by field
// depends on lgc_pkg
`timescale 1ns / 100ps

module langevin_gear_corrector_step_chk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_func,
   input  logic [lgc_pkg::PARTICLE_W-1:0]     req_particle,
   input  logic [lgc_pkg::ORDER_W-1:0]        req_order,
   input  logic signed [lgc_pkg::DATA_W-1:0]  req_force_x,
   input  logic signed [lgc_pkg::DATA_W-1:0]  req_force_y,
   input  logic signed [lgc_pkg::DATA_W-1:0]  req_force_z,
   input  logic signed [lgc_pkg::DATA_W-1:0]  req_noise_x,
   input  logic signed [lgc_pkg::DATA_W-1:0]  req_noise_y,
   input  logic signed [lgc_pkg::DATA_W-1:0]  req_noise_z,
   input  logic [lgc_pkg::DATA_W-1:0]         req_mass,
   input  logic [lgc_pkg::DATA_W-1:0]         req_inv_mass,
   input  logic [lgc_pkg::DATA_W-1:0]         req_rsqrt_mass,
   input  logic                               rsp_valid,
   input  logic [lgc_pkg::PARTICLE_W-1:0]     rsp_particle_out,
   input  logic signed [lgc_pkg::DATA_W-1:0]  rsp_pos_x,
   input  logic signed [lgc_pkg::DATA_W-1:0]  rsp_pos_y,
   input  logic signed [lgc_pkg::DATA_W-1:0]  rsp_pos_z,
   input  logic signed [lgc_pkg::DATA_W-1:0]  rsp_vel_x,
   input  logic signed [lgc_pkg::DATA_W-1:0]  rsp_vel_y,
   input  logic signed [lgc_pkg::DATA_W-1:0]  rsp_vel_z,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lgc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lgc_pkg::DATA_W-1:0]         csr_data,
   output int                                 fail_count,
   output int                                 pending_count
);
   import lgc_pkg::*;

   localparam logic [DATA_W-1:0] U_MAX   = 48'hFFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] POS_CAP = 48'h7FFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] NEG_CAP = 48'h8000_0000_0000;
   localparam longint S_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint S_MIN = -64'sh0000_8000_0000_0000;

   typedef struct {
      logic [PARTICLE_W-1:0] particle;
      logic [DATA_W-1:0]     pos [AXES];
      logic [DATA_W-1:0]     vel [AXES];
   } step_result_type;

   logic [DATA_W-1:0] deriv_rows [PARTICLES*ROWS*AXES];
   logic [DATA_W-1:0] half_dt_sq_q, inv_dt_q, gamma_q, noise_scale_q;
   step_result_type   step_results [$];

   // a*b >> 32 rounded, clipped at cap
   function automatic logic [DATA_W-1:0] mul_q32(input logic [DATA_W-1:0] a,
         input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] cap);
      logic [97:0] prod;
      logic [65:0] r;
      prod = {50'd0, a} * {50'd0, b} + 98'h8000_0000;
      r = prod[97:32];
      return (r > {18'd0, cap}) ? cap : r[DATA_W-1:0];
   endfunction

   // signed times unsigned; magnitude rounds, so ties go away from zero
   function automatic longint smul_q32(input longint a, input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] mag, r;
      mag = (a < 0) ? DATA_W'(-a) : DATA_W'(a);
      r   = mul_q32(mag, b, (a < 0) ? NEG_CAP : POS_CAP);
      return (a < 0) ? -longint'({16'd0, r}) : longint'({16'd0, r});
   endfunction

   function automatic longint clip(input longint v);
      return (v > S_MAX) ? S_MAX : ((v < S_MIN) ? S_MIN : v);
   endfunction

   function automatic longint sext(input logic [DATA_W-1:0] v);
      return longint'($signed(v));
   endfunction

   // one integrate step: updates the derivative rows and queues the result
   task automatic integrate_particle(input logic [PARTICLE_W-1:0] p,
         input logic [DATA_W-1:0] force_v [AXES], input logic [DATA_W-1:0] noise_v [AXES],
         input logic [DATA_W-1:0] mass, input logic [DATA_W-1:0] inv_mass,
         input logic [DATA_W-1:0] rsqrt_mass);
      longint y [ROWS][AXES];
      longint c [ROWS];
      longint f, fr, nz, a, e;
      logic [DATA_W-1:0] gam, nsd;
      step_result_type res;
      int base;
      base = int'(p) * ROWS * AXES;
      for (int k = 0; k < ROWS; k++)
         for (int ax = 0; ax < AXES; ax++) y[k][ax] = sext(deriv_rows[base + k*AXES + ax]);
      gam = mul_q32(gamma_q, mass, U_MAX);
      nsd = mul_q32(noise_scale_q, rsqrt_mass, U_MAX);
      res.particle = p;
      for (int ax = 0; ax < AXES; ax++) begin
         f  = smul_q32(sext(force_v[ax]), inv_mass);
         fr = smul_q32(smul_q32(y[1][ax], inv_dt_q), gam);
         nz = smul_q32(sext(noise_v[ax]), nsd);
         a  = clip(clip(f - fr) + nz);
         e  = clip(y[2][ax] - smul_q32(a, half_dt_sq_q));
         for (int k = 0; k < ROWS; k++) c[k] = clip(y[k][ax] - smul_q32(e, COEF[k]));
         // pascal triangle predictor, each sum clipped once
         y[0][ax] = clip(c[0] + c[1] + c[2] + c[3] + c[4] + c[5]);
         y[1][ax] = clip(c[1] + 2*c[2] + 3*c[3] + 4*c[4] + 5*c[5]);
         y[2][ax] = clip(c[2] + 3*c[3] + 6*c[4] + 10*c[5]);
         y[3][ax] = clip(c[3] + 4*c[4] + 10*c[5]);
         y[4][ax] = clip(c[4] + 5*c[5]);
         y[5][ax] = c[5];
         res.pos[ax] = y[0][ax][DATA_W-1:0];
         res.vel[ax] = DATA_W'(smul_q32(y[1][ax], inv_dt_q));
      end
      for (int k = 0; k < ROWS; k++)
         for (int ax = 0; ax < AXES; ax++)
            deriv_rows[base + k*AXES + ax] = y[k][ax][DATA_W-1:0];
      step_results.push_back(res);
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] expv,
         input logic [DATA_W-1:0] actv);
      if (expv !== actv) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, expv, actv);
         fail_count++;
      end
   endtask

   assign pending_count = step_results.size();

   always @(posedge clock) begin
      logic [DATA_W-1:0] fv [AXES];
      logic [DATA_W-1:0] nv [AXES];
      step_result_type exp_r;
      if (reset) begin
         half_dt_sq_q  <= RST_HALF_DT_SQ;
         inv_dt_q      <= RST_INV_DT;
         gamma_q       <= RST_GAMMA;
         noise_scale_q <= RST_NOISE_SCALE;
         step_results.delete();
         fail_count = 0;
      end else begin
         // results are checked before this edge's request is predicted
         if (rsp_valid) begin
            if (step_results.size() == 0) begin
               $display("%0t unexpected result for particle %0d", $time, rsp_particle_out);
               fail_count++;
            end else begin
               exp_r = step_results.pop_front();
               compare_field("particle_out", DATA_W'(exp_r.particle),
                  DATA_W'(rsp_particle_out));
               compare_field("pos_x", exp_r.pos[0], rsp_pos_x);
               compare_field("pos_y", exp_r.pos[1], rsp_pos_y);
               compare_field("pos_z", exp_r.pos[2], rsp_pos_z);
               compare_field("vel_x", exp_r.vel[0], rsp_vel_x);
               compare_field("vel_y", exp_r.vel[1], rsp_vel_y);
               compare_field("vel_z", exp_r.vel[2], rsp_vel_z);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HALF_DT_SQ:  half_dt_sq_q  <= csr_data;
               CSR_INV_DT:      inv_dt_q      <= csr_data;
               CSR_GAMMA:       gamma_q       <= csr_data;
               CSR_NOISE_SCALE: noise_scale_q <= csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            fv = '{req_force_x, req_force_y, req_force_z};
            nv = '{req_noise_x, req_noise_y, req_noise_z};
            if (req_func == FUNC_LOAD) begin
               if (int'(req_particle) < PARTICLES && int'(req_order) < ROWS)
                  for (int ax = 0; ax < AXES; ax++)
                     deriv_rows[(int'(req_particle)*ROWS + int'(req_order))*AXES + ax] = fv[ax];
            end else begin
               integrate_particle(req_particle, fv, nv, req_mass, req_inv_mass, req_rsqrt_mass);
            end
         end
      end
   end

endmodule

// ----- sim/langevin_gear_corrector_step_tb.sv -----
// testbench top for the gear corrector step: clock, reset, stimulus and verdict
// depends on lgc_pkg, the block and langevin_gear_corrector_step_chk
`timescale 1ns / 100ps

module langevin_gear_corrector_step_tb;
   import lgc_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1040;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 10;
   localparam logic [DATA_W-1:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] S48_MIN = 48'h8000_0000_0000;
   localparam logic [DATA_W-1:0] U48_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] Q_ONE   = 48'h0001_0000_0000;

   typedef struct {
      logic                  func;
      logic [PARTICLE_W-1:0] particle;
      logic [ORDER_W-1:0]    order;
      logic [DATA_W-1:0]     force_v [AXES];
      logic [DATA_W-1:0]     noise_v [AXES];
      logic [DATA_W-1:0]     mass, inv_mass, rsqrt_mass;
   } particle_req_type;

   logic clock, reset, start, busy;
   logic req_func;
   logic [PARTICLE_W-1:0] req_particle;
   logic [ORDER_W-1:0] req_order;
   logic signed [DATA_W-1:0] req_force_x, req_force_y, req_force_z;
   logic signed [DATA_W-1:0] req_noise_x, req_noise_y, req_noise_z;
   logic [DATA_W-1:0] req_mass, req_inv_mass, req_rsqrt_mass;
   logic rsp_valid;
   logic [PARTICLE_W-1:0] rsp_particle_out;
   logic signed [DATA_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [DATA_W-1:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_data;
   int fail_count, pending_count;
   int cycle_count;

   // rows loaded so far per particle; integrates only go to fully loaded ones
   logic [ROWS-1:0] rows_loaded [PARTICLES];
   int random_sent;

   langevin_gear_corrector_step u_top (.*);

   langevin_gear_corrector_step_chk u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // mix of small, extreme and fully random 48-bit values
   function automatic logic [DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)
         return DATA_W'($signed({$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom}) >>> 2);
      else if (sel < 7) begin
         case ($urandom_range(0, 4))
            0: return S48_MAX;
            1: return S48_MIN;
            2: return U48_MAX;
            3: return Q_ONE;
            default: return '0;
         endcase
      end
      return DATA_W'({$urandom, $urandom});
   endfunction

   // mass terms mostly between one and four so the state does not pin at saturation
   function automatic logic [DATA_W-1:0] pick_mass();
      if ($urandom_range(0, 9) < 8)
         return DATA_W'($urandom_range(1 << 28, 1 << 30)) << 4;
      return pick_value();
   endfunction

   function automatic particle_req_type make_req(input logic func, input int p, input int ord);
      particle_req_type r;
      r.func = func;
      r.particle = PARTICLE_W'(p);
      r.order = ORDER_W'(ord);
      for (int ax = 0; ax < AXES; ax++) begin
         r.force_v[ax] = pick_value();
         r.noise_v[ax] = pick_value();
      end
      r.mass = pick_mass();
      r.inv_mass = pick_mass();
      r.rsqrt_mass = pick_mass();
      return r;
   endfunction

   // drives one request, waits for the edge of its transfer, then may leave an idle gap
   task automatic send_req(input particle_req_type r);
      int gap;
      req_func       <= r.func;
      req_particle   <= r.particle;
      req_order      <= r.order;
      req_force_x    <= r.force_v[0];
      req_force_y    <= r.force_v[1];
      req_force_z    <= r.force_v[2];
      req_noise_x    <= r.noise_v[0];
      req_noise_y    <= r.noise_v[1];
      req_noise_z    <= r.noise_v[2];
      req_mass       <= r.mass;
      req_inv_mass   <= r.inv_mass;
      req_rsqrt_mass <= r.rsqrt_mass;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.func == FUNC_LOAD && int'(r.order) < ROWS)
         rows_loaded[r.particle][r.order] = 1'b1;
      // idle gaps: mostly none, some short, a few long
      gap = $urandom_range(0, 99);
      if (gap >= 55) begin
         start <= 1'b0;
         repeat (gap < 90 ? $urandom_range(1, 3) : $urandom_range(5, 40)) @(posedge clock);
      end
   endtask

   task automatic load_all_rows(input int p);
      for (int k = 0; k < ROWS; k++) send_req(make_req(FUNC_LOAD, p, k));
   endtask

   // csr writes only once the pipeline has drained
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_csr(input logic [DATA_W-1:0] hdt, input logic [DATA_W-1:0] idt,
         input logic [DATA_W-1:0] gam, input logic [DATA_W-1:0] nsc);
      wait_idle();
      write_csr(CSR_HALF_DT_SQ, hdt);
      write_csr(CSR_INV_DT, idt);
      write_csr(CSR_GAMMA, gam);
      write_csr(CSR_NOISE_SCALE, nsc);
   endtask

   // well-formed traffic over a small pool of particles plus some noise
   task automatic random_phase(input int count);
      int pool [8];
      int p, sel, stop_at;
      particle_req_type r;
      for (int i = 0; i < 8; i++) pool[i] = $urandom_range(0, PARTICLES - 1);
      pool[0] = $urandom_range(0, 1) ? 0 : PARTICLES - 1;
      stop_at = random_sent + count;
      while (random_sent < stop_at) begin
         p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PARTICLES - 1)
                                          : pool[$urandom_range(0, 7)];
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            // row index past the last row: ignored by the block
            send_req(make_req(FUNC_LOAD, p, $urandom_range(ROWS, 7)));
            random_sent++;
         end else if (rows_loaded[p] != '1) begin
            load_all_rows(p);
            random_sent += ROWS;
         end else if (sel < 22) begin
            send_req(make_req(FUNC_LOAD, p, $urandom_range(0, ROWS - 1)));
            random_sent++;
         end else begin
            r = make_req(FUNC_INTEGRATE, p, $urandom_range(0, 7));
            send_req(r);
            random_sent++;
         end
      end
   endtask

   initial begin
      particle_req_type r;
      cycle_count = 0;
      random_sent = 0;
      for (int i = 0; i < PARTICLES; i++) rows_loaded[i] = '0;
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_INTEGRATE;
      req_particle = '0;
      req_order = '0;
      {req_force_x, req_force_y, req_force_z} = '0;
      {req_noise_x, req_noise_y, req_noise_z} = '0;
      {req_mass, req_inv_mass, req_rsqrt_mass} = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme rows on the first and last particle under reset settings
      for (int k = 0; k < ROWS; k++) begin
         r = make_req(FUNC_LOAD, 0, k);
         r.force_v = '{S48_MAX, S48_MIN, '0};
         send_req(r);
         r = make_req(FUNC_LOAD, PARTICLES - 1, k);
         r.force_v = '{Q_ONE, '0, U48_MAX};
         send_req(r);
      end
      // out-of-range rows are dropped
      send_req(make_req(FUNC_LOAD, 5, 6));
      send_req(make_req(FUNC_LOAD, 5, 7));
      r = make_req(FUNC_INTEGRATE, 0, 0);
      r.force_v = '{S48_MAX, S48_MIN, S48_MAX};
      r.noise_v = '{S48_MIN, S48_MAX, '0};
      r.mass = U48_MAX;
      r.inv_mass = U48_MAX;
      r.rsqrt_mass = U48_MAX;
      send_req(r);
      r = make_req(FUNC_INTEGRATE, PARTICLES - 1, 0);
      r.force_v = '{'0, '0, '0};
      r.mass = '0;
      r.inv_mass = '0;
      r.rsqrt_mass = '0;
      send_req(r);
      // back-to-back integrates on one particle exercise the write-back hazard
      send_req(make_req(FUNC_INTEGRATE, 0, 0));
      send_req(make_req(FUNC_INTEGRATE, 0, 0));

      // settings: extremes, zeros, then a noisy realistic set, then random ones
      write_all_csr(U48_MAX, U48_MAX, U48_MAX, U48_MAX);
      send_req(make_req(FUNC_INTEGRATE, 0, 0));
      send_req(make_req(FUNC_INTEGRATE, PARTICLES - 1, 0));
      // unused register indexes must change nothing
      wait_idle();
      for (int i = CSR_NOISE_SCALE + 1; i < (1 << CSR_IDX_W); i++)
         write_csr(CSR_IDX_W'(i), '0);
      write_all_csr('0, '0, '0, '0);
      random_phase(RANDOM_ITEMS / 6);
      write_all_csr(RST_HALF_DT_SQ, RST_INV_DT, RST_GAMMA, 48'd858993459);
      random_phase(RANDOM_ITEMS / 3);
      for (int ph = 0; ph < 3; ph++) begin
         write_all_csr(DATA_W'($urandom_range(1, 1 << 20)), DATA_W'({$urandom_range(0, 255), $urandom}),
            DATA_W'({$urandom_range(0, 3), $urandom}), DATA_W'({$urandom_range(0, 3), $urandom}));
         random_phase(RANDOM_ITEMS / 6);
      end
      write_all_csr(DATA_W'({$urandom, $urandom}), DATA_W'({$urandom, $urandom}),
         DATA_W'({$urandom, $urandom}), DATA_W'({$urandom, $urandom}));
      random_phase(RANDOM_ITEMS / 12);

      wait_idle();
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
